// ===== rtl/gklb_pkg.sv =====
// Shared types, register codes and table functions for the Gaussian kernel bounds block.
// Used by every module in this folder; depends on nothing.
package gklb_pkg;

   typedef struct packed {
      logic signed [63:0] ip;
      logic [63:0]        l2;
      logic [63:0]        u2;
      logic [31:0]        w;
      logic [47:0]        s;
      logic [47:0]        qn;
   } gklb_job_type;

   localparam logic [0:0] CSR_KERNEL_GAMMA = 1'd0;
   localparam logic [0:0] CSR_FLAT_GAP     = 1'd1;

   localparam logic [63:0] T_LIMIT = 64'd32 << 24;

   // exp(-x) for x with 30 fraction bits, series up to the x^16 term with truncated terms.
   function automatic logic [30:0] exp_series(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] acc;
      term = 64'd1 << 30;
      acc  = 64'sd1 <<< 30;
      for (int k = 1; k <= 16; k++) begin
         term = ((term * x) >> 30) / 64'(k);
         if (k % 2 == 1) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      exp_series = (acc > 0) ? 31'(acc) : '0;
   endfunction

   // exp(-n) as repeated rounded products of exp(-1), 30 fraction bits.
   function automatic logic [30:0] int_entry(input int n, input logic [30:0] last);
      logic [63:0] v;
      v = 64'd1 << 30;
      for (int i = 1; i < 32; i++) begin
         if (i <= n) begin
            v = (v * 64'(last) + (64'd1 << 29)) >> 30;
         end
      end
      int_entry = 31'(v);
   endfunction

endpackage

// ===== rtl/gaussian_kernel_linear_bounds.sv =====
// Top level of the Gaussian kernel bounds block: configuration registers and the
// front end, queue and bound unit. Depends on gklb_pkg, gklb_front, gklb_queue, gklb_back.
//
// Each transfer on the req_ channel carries one dimension of a query point against a tree
// node. The front end takes one dimension per cycle while req_ready is high, accumulating
// the inner product and the squared nearest and farthest box distances in two pipeline
// stages. The transfer with req_last_dim set closes the vector and produces exactly one
// transfer on rsp_; others produce none. Closed vectors wait in a two-entry queue.
// The bound unit works through one vector at a time and takes a new one only after its
// result is in the output register. Its work is set by its single shared 32x32 multiplier
// (each wide product passes through S_M0, S_M1 and S_M2, up to fifteen products), its
// one-bit-per-cycle divider (29 and 25 steps) and a normalising shift of up to 25 steps.
// A stalled receiver holds the result in the output register; the bound unit and then the
// queue fill, after which req_ready falls. Synchronous reset clears the accumulators and
// all handshake state and sets kernel_gamma to 1.0 and flat_gap_threshold to one LSB.
// The user writes registers through the csr_ port only while no vector is in flight;
// the block itself does not enforce this.
module gaussian_kernel_linear_bounds #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [0:0]          csr_index,
   input  logic [31:0]         csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [23:0]  req_query_coord,
   input  logic signed [31:0]  req_centroid_weighted_coord,
   input  logic signed [23:0]  req_box_low,
   input  logic signed [23:0]  req_box_high,
   input  logic [31:0]         req_weight_sum,
   input  logic [47:0]         req_weighted_sq_norm_sum,
   input  logic [47:0]         req_query_sq_norm,
   input  logic                req_last_dim,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [47:0]         rsp_lower_bound,
   output logic [47:0]         rsp_upper_bound,
   output logic                rsp_flat_case
);

   logic [31:0]            kernel_gamma_ff;
   logic [31:0]            flat_gap_threshold_ff;
   logic                   fq_valid;
   logic                   fq_ready;
   gklb_pkg::gklb_job_type fq_job;
   logic                   qb_valid;
   logic                   qb_ready;
   gklb_pkg::gklb_job_type qb_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_gamma_ff       <= 32'd16777216;
         flat_gap_threshold_ff <= 32'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gklb_pkg::CSR_KERNEL_GAMMA: kernel_gamma_ff       <= csr_write_data;
            gklb_pkg::CSR_FLAT_GAP:     flat_gap_threshold_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   gklb_front u_front (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_ready                   (req_ready),
      .req_query_coord             (req_query_coord),
      .req_centroid_weighted_coord (req_centroid_weighted_coord),
      .req_box_low                 (req_box_low),
      .req_box_high                (req_box_high),
      .req_weight_sum              (req_weight_sum),
      .req_weighted_sq_norm_sum    (req_weighted_sq_norm_sum),
      .req_query_sq_norm           (req_query_sq_norm),
      .req_last_dim                (req_last_dim),
      .job_valid                   (fq_valid),
      .job_ready                   (fq_ready),
      .job                         (fq_job)
   );

   gklb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_job),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_job)
   );

   gklb_back #(
      .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .kernel_gamma       (kernel_gamma_ff),
      .flat_gap_threshold (flat_gap_threshold_ff),
      .job_valid          (qb_valid),
      .job_ready          (qb_ready),
      .job                (qb_job),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_lower_bound    (rsp_lower_bound),
      .rsp_upper_bound    (rsp_upper_bound),
      .rsp_flat_case      (rsp_flat_case)
   );

endmodule

// ===== rtl/gklb_front.sv =====
// Front end: takes one dimension per transfer, forms products and squared distances,
// accumulates them and hands a finished node vector to the queue. Depends on gklb_pkg.
module gklb_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [23:0]   req_query_coord,
   input  logic signed [31:0]   req_centroid_weighted_coord,
   input  logic signed [23:0]   req_box_low,
   input  logic signed [23:0]   req_box_high,
   input  logic [31:0]          req_weight_sum,
   input  logic [47:0]          req_weighted_sq_norm_sum,
   input  logic [47:0]          req_query_sq_norm,
   input  logic                 req_last_dim,
   output logic                 job_valid,
   input  logic                 job_ready,
   output gklb_pkg::gklb_job_type job
);

   localparam logic signed [64:0] IP_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] IP_MIN = -IP_MAX;

   logic                a_valid_ff;
   logic                a_last_ff;
   logic signed [55:0]  prod_ff;
   logic [49:0]         nsq_ff;
   logic [49:0]         fsq_ff;
   logic [31:0]         w_ff;
   logic [47:0]         s_ff;
   logic [47:0]         qn_ff;
   logic signed [63:0]  ip_ff;
   logic [63:0]         near_ff;
   logic [63:0]         far_ff;

   logic signed [55:0]  prod_in;
   logic signed [24:0]  dql;
   logic signed [24:0]  dqh;
   logic [24:0]         dl;
   logic [24:0]         dh;
   logic [24:0]         dn;
   logic [24:0]         df;
   logic signed [64:0]  ip_sum;
   logic signed [63:0]  ip_next;
   logic [64:0]         near_sum;
   logic [64:0]         far_sum;
   logic [63:0]         near_next;
   logic [63:0]         far_next;
   logic                a_adv;
   logic                take;

   assign prod_in = req_query_coord * req_centroid_weighted_coord;
   assign dql = {req_query_coord[23], req_query_coord} - {req_box_low[23], req_box_low};
   assign dqh = {req_query_coord[23], req_query_coord} - {req_box_high[23], req_box_high};
   assign dl  = dql[24] ? 25'(-dql) : 25'(dql);
   assign dh  = dqh[24] ? 25'(-dqh) : 25'(dqh);

   always_comb begin
      if (req_query_coord < req_box_low) begin
         dn = dl;
      end else if (req_query_coord > req_box_high) begin
         dn = dh;
      end else begin
         dn = '0;
      end
      df = (dl > dh) ? dl : dh;
   end

   assign ip_sum = {ip_ff[63], ip_ff} + 65'(prod_ff);
   always_comb begin
      priority if (ip_sum > IP_MAX) begin
         ip_next = 64'(IP_MAX);
      end else if (ip_sum < IP_MIN) begin
         ip_next = 64'(IP_MIN);
      end else begin
         ip_next = ip_sum[63:0];
      end
   end
   assign near_sum  = {1'b0, near_ff} + 65'(nsq_ff);
   assign far_sum   = {1'b0, far_ff} + 65'(fsq_ff);
   assign near_next = near_sum[64] ? '1 : near_sum[63:0];
   assign far_next  = far_sum[64] ? '1 : far_sum[63:0];

   assign a_adv     = a_valid_ff && (!a_last_ff || job_ready);
   assign req_ready = !a_valid_ff || a_adv;
   assign take      = req_valid && req_ready;
   assign job_valid = a_valid_ff && a_last_ff;
   assign job       = '{ip: ip_next, l2: near_next, u2: far_next, w: w_ff, s: s_ff,
                        qn: qn_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         ip_ff      <= '0;
         near_ff    <= '0;
         far_ff     <= '0;
      end else begin
         if (take) begin
            a_valid_ff <= 1'b1;
         end else if (a_adv) begin
            a_valid_ff <= 1'b0;
         end
         if (a_adv) begin
            if (a_last_ff) begin
               ip_ff   <= '0;
               near_ff <= '0;
               far_ff  <= '0;
            end else begin
               ip_ff   <= ip_next;
               near_ff <= near_next;
               far_ff  <= far_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_last_ff <= req_last_dim;
         prod_ff   <= prod_in;
         nsq_ff    <= dn * dn;
         fsq_ff    <= df * df;
         w_ff      <= req_weight_sum;
         s_ff      <= req_weighted_sq_norm_sum;
         qn_ff     <= req_query_sq_norm;
      end
   end

endmodule

// ===== rtl/gklb_queue.sv =====
// Two-entry queue of node vectors between the front end and the bound unit.
// Depends on gklb_pkg for the entry type.
module gklb_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  gklb_pkg::gklb_job_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gklb_pkg::gklb_job_type out_data
);

   gklb_pkg::gklb_job_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2) else $error("queue count out of range");
   a_count_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a push");
`endif

endmodule

// ===== rtl/gklb_back.sv =====
// Bound unit: works through one node vector with a shared 32x32 multiplier, a radix-2
// divider and the exp tables, then holds the result in an output register. Depends on gklb_pkg.
module gklb_back #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [31:0]            kernel_gamma,
   input  logic [31:0]            flat_gap_threshold,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  gklb_pkg::gklb_job_type job,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [47:0]            rsp_lower_bound,
   output logic [47:0]            rsp_upper_bound,
   output logic                   rsp_flat_case
);

   localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_M0   = 5'd1;
   localparam logic [4:0] S_M1   = 5'd2;
   localparam logic [4:0] S_M2   = 5'd3;
   localparam logic [4:0] S_IPD  = 5'd4;
   localparam logic [4:0] S_MM   = 5'd5;
   localparam logic [4:0] S_TL   = 5'd6;
   localparam logic [4:0] S_E0   = 5'd7;
   localparam logic [4:0] S_E1   = 5'd8;
   localparam logic [4:0] S_E2   = 5'd9;
   localparam logic [4:0] S_E3   = 5'd10;
   localparam logic [4:0] S_E4   = 5'd11;
   localparam logic [4:0] S_E5   = 5'd12;
   localparam logic [4:0] S_EL   = 5'd13;
   localparam logic [4:0] S_TU   = 5'd14;
   localparam logic [4:0] S_EU   = 5'd15;
   localparam logic [4:0] S_TM   = 5'd16;
   localparam logic [4:0] S_DV   = 5'd17;
   localparam logic [4:0] S_TD   = 5'd18;
   localparam logic [4:0] S_LB   = 5'd19;
   localparam logic [4:0] S_LB2  = 5'd20;
   localparam logic [4:0] S_UB   = 5'd21;
   localparam logic [4:0] S_WL2  = 5'd22;
   localparam logic [4:0] S_DMX  = 5'd23;
   localparam logic [4:0] S_DCL  = 5'd24;
   localparam logic [4:0] S_NRM  = 5'd25;
   localparam logic [4:0] S_R    = 5'd26;
   localparam logic [4:0] S_RE   = 5'd27;
   localparam logic [4:0] S_WE   = 5'd28;
   localparam logic [4:0] S_DONE = 5'd29;

   localparam logic [30:0] LAST_ENTRY = gklb_pkg::exp_series(64'd1 << 30);

   logic [30:0] frac_tab [EXP_TABLE_DEPTH + 1];
   logic [30:0] int_tab  [32];

   for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_frac
      localparam logic [63:0] X = (64'(gi) << 30) / EXP_TABLE_DEPTH;
      assign frac_tab[gi] = gklb_pkg::exp_series(X);
   end
   for (genvar gn = 0; gn < 32; gn++) begin : g_int
      assign int_tab[gn] = gklb_pkg::int_entry(gn, LAST_ENTRY);
   end

   logic [4:0]             state_ff;
   logic [4:0]             mret_ff;
   logic [4:0]             eret_ff;
   logic [4:0]             dret_ff;
   gklb_pkg::gklb_job_type job_ff;
   logic [31:0]            mul_a_ff;
   logic [63:0]            mul_b_ff;
   logic [63:0]            mlo_ff;
   logic [63:0]            mhi_ff;
   logic [95:0]            prod_ff;
   logic signed [49:0]     ipd_ff;
   logic [63:0]            gap_ff;
   logic                   flat_ff;
   logic [49:0]            m_ff;
   logic [63:0]            targ_ff;
   logic [4:0]             n_ff;
   logic [IW-1:0]          idx_ff;
   logic [23:0]            rem_ff;
   logic [30:0]            ta_ff;
   logic [30:0]            ef_ff;
   logic [24:0]            eres_ff;
   logic [24:0]            el_ff;
   logic [24:0]            eu_ff;
   logic [39:0]            drem_ff;
   logic [39:0]            div_ff;
   logic [28:0]            dsh_ff;
   logic [28:0]            quo_ff;
   logic [4:0]             cnt_ff;
   logic [63:0]            wl2_ff;
   logic [63:0]            dmax_ff;
   logic [63:0]            d_ff;
   logic [47:0]            lb_ff;
   logic [47:0]            ub_ff;
   logic                   out_valid_ff;
   logic [47:0]            out_lb_ff;
   logic [47:0]            out_ub_ff;
   logic                   out_flat_ff;

   logic [31:0]            mul_sel;
   logic [63:0]            mul_out;
   logic [IW-1:0]          tab_idx;
   logic [30:0]            tab_rd;
   logic [23+IW:0]         pos;
   logic [41:0]            trial;
   logic [62:0]            neg_mag;
   logic [63:0]            neg_rnd;
   logic signed [51:0]     msum;
   logic [63:0]            rnd;
   logic [63:0]            m_wide;
   logic                   out_load;

   assign mul_sel = (state_ff == S_M0) ? mul_b_ff[31:0] : mul_b_ff[63:32];
   assign mul_out = mul_a_ff * mul_sel;
   assign tab_idx = (state_ff == S_E1) ? idx_ff : idx_ff + IW'(1);
   assign tab_rd  = frac_tab[tab_idx];
   assign pos     = (24 + IW)'(targ_ff[23:0]) * (24 + IW)'(EXP_TABLE_DEPTH);
   assign trial   = {1'b0, drem_ff, dsh_ff[28]} - {2'b00, div_ff};
   assign neg_mag = 63'(-job_ff.ip);
   assign neg_rnd = 64'(neg_mag) + 64'd32767;
   assign msum    = $signed({4'b0, prod_ff[79:32]}) + $signed({4'b0, job_ff.s})
                    - $signed({{2{ipd_ff[49]}}, ipd_ff});
   assign rnd     = prod_ff[63:0] + (64'd1 << 35);
   assign m_wide  = {14'b0, m_ff};
   assign out_load = (state_ff == S_DONE) && (!out_valid_ff || rsp_ready);

   assign job_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = out_valid_ff;
   assign rsp_lower_bound = out_lb_ff;
   assign rsp_upper_bound = out_ub_ff;
   assign rsp_flat_case   = out_flat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job;
                  mul_a_ff <= job.w;
                  mul_b_ff <= {16'b0, job.qn};
                  mret_ff  <= S_IPD;
                  state_ff <= S_M0;
               end
            end
            S_M0: begin
               mlo_ff   <= mul_out;
               state_ff <= S_M1;
            end
            S_M1: begin
               mhi_ff   <= mul_out;
               state_ff <= S_M2;
            end
            S_M2: begin
               prod_ff  <= {mhi_ff, 32'b0} + {32'b0, mlo_ff};
               state_ff <= mret_ff;
            end
            S_IPD: begin
               if (job_ff.ip[63]) begin
                  ipd_ff <= -$signed({1'b0, neg_rnd[63:15]});
               end else begin
                  ipd_ff <= $signed({2'b00, job_ff.ip[62:15]});
               end
               gap_ff   <= (job_ff.u2 > job_ff.l2) ? job_ff.u2 - job_ff.l2 : '0;
               state_ff <= S_MM;
            end
            S_MM: begin
               m_ff     <= msum[51] ? '0 : msum[49:0];
               flat_ff  <= gap_ff < {16'b0, flat_gap_threshold, 16'b0};
               mul_a_ff <= kernel_gamma;
               mul_b_ff <= job_ff.l2;
               mret_ff  <= S_TL;
               state_ff <= S_M0;
            end
            S_TL: begin
               targ_ff  <= prod_ff[95:32];
               eret_ff  <= S_EL;
               state_ff <= S_E0;
            end
            S_E0: begin
               if (targ_ff >= gklb_pkg::T_LIMIT) begin
                  eres_ff  <= '0;
                  state_ff <= eret_ff;
               end else begin
                  n_ff     <= targ_ff[28:24];
                  idx_ff   <= pos[23+IW:24];
                  rem_ff   <= pos[23:0];
                  state_ff <= S_E1;
               end
            end
            S_E1: begin
               ta_ff    <= tab_rd;
               state_ff <= S_E2;
            end
            S_E2: begin
               if (ta_ff >= tab_rd) begin
                  mul_a_ff <= 32'(rem_ff);
                  mul_b_ff <= 64'(ta_ff - tab_rd);
                  mret_ff  <= S_E3;
                  state_ff <= S_M0;
               end else begin
                  ef_ff    <= ta_ff;
                  state_ff <= S_E4;
               end
            end
            S_E3: begin
               ef_ff    <= ta_ff - prod_ff[54:24];
               state_ff <= S_E4;
            end
            S_E4: begin
               mul_a_ff <= 32'(int_tab[n_ff]);
               mul_b_ff <= 64'(ef_ff);
               mret_ff  <= S_E5;
               state_ff <= S_M0;
            end
            S_E5: begin
               eres_ff  <= rnd[60:36];
               state_ff <= eret_ff;
            end
            S_EL: begin
               el_ff    <= eres_ff;
               mul_a_ff <= kernel_gamma;
               mul_b_ff <= job_ff.u2;
               mret_ff  <= S_TU;
               state_ff <= S_M0;
            end
            S_TU: begin
               targ_ff  <= prod_ff[95:32];
               eret_ff  <= S_EU;
               state_ff <= S_E0;
            end
            S_EU: begin
               eu_ff <= eres_ff;
               if (job_ff.w == '0) begin
                  lb_ff    <= '0;
                  ub_ff    <= '0;
                  state_ff <= S_DONE;
               end else begin
                  mul_a_ff <= kernel_gamma;
                  mul_b_ff <= m_wide;
                  mret_ff  <= S_TM;
                  state_ff <= S_M0;
               end
            end
            S_TM: begin
               if (prod_ff[95:64] == '0 && prod_ff[63:0] < {3'b0, job_ff.w, 29'b0}) begin
                  drem_ff  <= 40'(prod_ff[63:29]);
                  div_ff   <= 40'(job_ff.w);
                  dsh_ff   <= prod_ff[28:0];
                  quo_ff   <= '0;
                  cnt_ff   <= 5'd29;
                  dret_ff  <= S_TD;
                  state_ff <= S_DV;
               end else begin
                  targ_ff  <= gklb_pkg::T_LIMIT;
                  eret_ff  <= S_LB;
                  state_ff <= S_E0;
               end
            end
            S_DV: begin
               if (!trial[41]) begin
                  drem_ff <= trial[39:0];
                  quo_ff  <= {quo_ff[27:0], 1'b1};
               end else begin
                  drem_ff <= {drem_ff[38:0], dsh_ff[28]};
                  quo_ff  <= {quo_ff[27:0], 1'b0};
               end
               dsh_ff <= {dsh_ff[27:0], 1'b0};
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  state_ff <= dret_ff;
               end
            end
            S_TD: begin
               targ_ff  <= 64'(quo_ff);
               eret_ff  <= S_LB;
               state_ff <= S_E0;
            end
            S_LB: begin
               mul_a_ff <= job_ff.w;
               mul_b_ff <= 64'(eres_ff);
               mret_ff  <= S_LB2;
               state_ff <= S_M0;
            end
            S_LB2: begin
               lb_ff    <= prod_ff[63:16];
               mul_a_ff <= job_ff.w;
               if (flat_ff) begin
                  mul_b_ff <= 64'(el_ff);
                  mret_ff  <= S_UB;
               end else begin
                  mul_b_ff <= job_ff.l2;
                  mret_ff  <= S_WL2;
               end
               state_ff <= S_M0;
            end
            S_UB: begin
               ub_ff    <= prod_ff[63:16];
               state_ff <= S_DONE;
            end
            S_WL2: begin
               wl2_ff   <= prod_ff[95:32];
               mul_a_ff <= job_ff.w;
               mul_b_ff <= gap_ff;
               mret_ff  <= S_DMX;
               state_ff <= S_M0;
            end
            S_DMX: begin
               dmax_ff  <= prod_ff[95:32];
               d_ff     <= (m_wide > wl2_ff) ? m_wide - wl2_ff : '0;
               state_ff <= S_DCL;
            end
            S_DCL: begin
               if (d_ff > dmax_ff) begin
                  d_ff <= dmax_ff;
               end
               state_ff <= S_NRM;
            end
            S_NRM: begin
               if (|dmax_ff[63:39]) begin
                  dmax_ff <= {1'b0, dmax_ff[63:1]};
                  d_ff    <= {1'b0, d_ff[63:1]};
               end else if (dmax_ff == '0) begin
                  quo_ff   <= '0;
                  state_ff <= S_R;
               end else begin
                  drem_ff  <= 40'(d_ff[38:1]);
                  div_ff   <= dmax_ff[39:0];
                  dsh_ff   <= {d_ff[0], 28'b0};
                  quo_ff   <= '0;
                  cnt_ff   <= 5'd25;
                  dret_ff  <= S_R;
                  state_ff <= S_DV;
               end
            end
            S_R: begin
               if (el_ff > eu_ff) begin
                  mul_a_ff <= 32'(quo_ff[24:0]);
                  mul_b_ff <= 64'(el_ff - eu_ff);
                  mret_ff  <= S_RE;
                  state_ff <= S_M0;
               end else begin
                  eres_ff  <= el_ff;
                  state_ff <= S_WE;
               end
            end
            S_RE: begin
               eres_ff  <= el_ff - prod_ff[48:24];
               state_ff <= S_WE;
            end
            S_WE: begin
               mul_a_ff <= job_ff.w;
               mul_b_ff <= 64'(eres_ff);
               mret_ff  <= S_UB;
               state_ff <= S_M0;
            end
            S_DONE: begin
               if (out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_lb_ff   <= lb_ff;
         out_ub_ff   <= ub_ff;
         out_flat_ff <= flat_ff;
      end
   end

`ifndef SYNTHESIS
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DV |-> cnt_ff != 5'd0) else $error("divider entered with no steps left");
   a_zero_weight: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && job_ff.w == '0 |-> lb_ff == '0 && ub_ff == '0)
      else $error("non-zero bound for zero weight sum");
   a_exp_return: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_E0 |-> eret_ff == S_EL || eret_ff == S_EU || eret_ff == S_LB)
      else $error("exp sequence has no valid return state");
`endif

endmodule
